[design/dss_pkg.sv]
// Shared types and constants of the disk seek scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package dss_pkg;

   localparam int CYL_W    = 16;
   localparam int TOTAL_W  = 22;
   localparam int DISK_W   = 17;
   localparam int MODE_W   = 2;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [TOTAL_W-1:0] TOTAL_MAX   = 22'h3FFFFF;
   localparam logic [DISK_W-1:0]  DISK_RESET  = 17'd5000;

   localparam logic [ADDR_W-1:0] ADDR_MODE  = 4'h0;
   localparam logic [ADDR_W-1:0] ADDR_START = 4'h4;
   localparam logic [ADDR_W-1:0] ADDR_DISK  = 4'h8;

   localparam logic [MODE_W-1:0] MODE_SSTF  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_LOOK  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CSCAN = 2'd2;

   // selection criterion of one scan pass
   typedef enum logic [1:0] {
      PH_NEAR  = 2'd0,   // nearest to head
      PH_HIGH  = 2'd1,   // smallest at or above start
      PH_DOWN  = 2'd2,   // largest below start
      PH_UPLOW = 2'd3    // smallest below start
   } phase_type;

   // cylinder source of one visit
   typedef enum logic [1:0] {
      VS_START = 2'd0,
      VS_BEST  = 2'd1,
      VS_LAST  = 2'd2,
      VS_ZERO  = 2'd3
   } vsel_type;

   typedef struct packed {
      logic      store_wr;
      logic      served_clr;
      logic      scan_clr;
      logic      rd_en;
      logic      visit;
      vsel_type  vsel;
      logic      done;
      phase_type phase;
   } cmd_type;

   typedef struct packed {
      logic found;
      logic slot_ok;
      logic done_ok;
   } sts_type;

endpackage
`default_nettype wire

[design/dss_datapath.sv]
// Datapath: request memory, served marks, scan comparator, head/total, result registers.
// Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dss_datapath import dss_pkg::*; #(
   parameter int MAX_REQUESTS = 32,
   parameter int CYL_BITS     = 16,
   localparam int IDX_W       = $clog2(MAX_REQUESTS)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire cmd_type            cmd,
   output sts_type                 sts,
   input  wire logic [IDX_W-1:0]   wr_ix,
   input  wire logic [IDX_W-1:0]   rd_ix,
   input  wire logic [CYL_W-1:0]   req_cylinder,
   input  wire logic [CYL_W-1:0]   start_cylinder,
   input  wire logic [DISK_W-1:0]  disk_cylinders,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CYL_W-1:0]        rsp_position,
   output logic [TOTAL_W-1:0]      rsp_seek_total,
   output logic                    rsp_final_item
);

   localparam int LW    = (CYL_BITS > DISK_W) ? CYL_BITS : DISK_W;
   localparam int SUM_W = ((CYL_BITS > TOTAL_W) ? CYL_BITS : TOTAL_W) + 1;

   logic [CYL_BITS-1:0] store_mem [MAX_REQUESTS];
   logic [CYL_BITS-1:0] q_ff;
   logic                rd_v_ff;
   logic [IDX_W-1:0]    rd_ix_ff;

   logic [MAX_REQUESTS-1:0] served_ff, served_in;
   logic                    found_ff, found_in;
   logic [CYL_BITS-1:0]     best_key_ff, best_key_in;
   logic [CYL_BITS-1:0]     best_val_ff, best_val_in;
   logic [IDX_W-1:0]        best_ix_ff, best_ix_in;

   logic [CYL_BITS-1:0] cur_ff, cur_in;
   logic [TOTAL_W-1:0]  total_ff, total_in;

   logic                pend_v_ff, pend_v_in;
   logic [CYL_BITS-1:0] pend_pos_ff, pend_pos_in;
   logic [TOTAL_W-1:0]  pend_tot_ff, pend_tot_in;
   logic                rsp_v_ff, rsp_v_in;
   logic [CYL_BITS-1:0] rsp_pos_ff, rsp_pos_in;
   logic [TOTAL_W-1:0]  rsp_tot_ff, rsp_tot_in;
   logic                rsp_fin_ff, rsp_fin_in;

   logic [CYL_BITS+CYL_W-1:0] cyl_ext, start_ext;
   logic [CYL_BITS-1:0]       cyl_c, start_c, last_c, key, pos, base, gap_v, gap_s;
   logic [LW-1:0]             last_w, mask_w;
   logic                      above, elig, take, rsp_free, load_rsp;
   logic [TOTAL_W-1:0]        base_tot;
   logic [SUM_W-1:0]          sum;
   logic [CYL_W+CYL_BITS-1:0] out_ext;

   assign cyl_ext   = {{CYL_BITS{1'b0}}, req_cylinder};
   assign cyl_c     = cyl_ext[CYL_BITS-1:0];
   assign start_ext = {{CYL_BITS{1'b0}}, start_cylinder};
   assign start_c   = start_ext[CYL_BITS-1:0];

   // last cylinder of the disk, saturated to the cylinder range
   always_comb begin
      mask_w = LW'({CYL_BITS{1'b1}});
      last_w = (disk_cylinders == '0) ? '0 : LW'(disk_cylinders) - LW'(1);
      if (last_w > mask_w) begin
         last_w = mask_w;
      end
      last_c = last_w[CYL_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (cmd.store_wr) begin
         store_mem[wr_ix] <= cyl_c;
      end
      if (cmd.rd_en) begin
         q_ff <= store_mem[rd_ix];
      end
      rd_ix_ff <= rd_ix;
   end

   // scan compare stage
   always_comb begin
      above = q_ff >= start_c;
      gap_s = (cur_ff >= q_ff) ? cur_ff - q_ff : q_ff - cur_ff;
      case (cmd.phase)
         PH_NEAR: begin
            elig = 1'b1;
            key  = gap_s;
         end
         PH_HIGH: begin
            elig = above;
            key  = q_ff;
         end
         PH_DOWN: begin
            elig = !above;
            key  = ~q_ff;
         end
         default: begin
            elig = !above;
            key  = q_ff;
         end
      endcase
      take = rd_v_ff && !served_ff[rd_ix_ff] && elig && (!found_ff || key < best_key_ff);

      found_in    = found_ff;
      best_key_in = best_key_ff;
      best_val_in = best_val_ff;
      best_ix_in  = best_ix_ff;
      if (cmd.scan_clr) begin
         found_in = 1'b0;
      end else if (take) begin
         found_in    = 1'b1;
         best_key_in = key;
         best_val_in = q_ff;
         best_ix_in  = rd_ix_ff;
      end

      served_in = served_ff;
      if (cmd.served_clr) begin
         served_in = '0;
      end else if (cmd.visit && cmd.vsel == VS_BEST) begin
         served_in[best_ix_ff] = 1'b1;
      end
   end

   // head move and saturating seek total
   always_comb begin
      case (cmd.vsel)
         VS_START: pos = start_c;
         VS_BEST:  pos = best_val_ff;
         VS_LAST:  pos = last_c;
         default:  pos = '0;
      endcase
      base     = (cmd.vsel == VS_START) ? start_c : cur_ff;
      base_tot = (cmd.vsel == VS_START) ? '0 : total_ff;
      gap_v    = (base >= pos) ? base - pos : pos - base;
      sum      = SUM_W'(base_tot) + SUM_W'(gap_v);
      cur_in   = cur_ff;
      total_in = total_ff;
      if (cmd.visit) begin
         cur_in   = pos;
         total_in = (sum > SUM_W'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_W-1:0];
      end
   end

   // one pending result held back until it is known whether it is the last
   always_comb begin
      rsp_free    = !rsp_v_ff || rsp_ready;
      load_rsp    = (cmd.visit && pend_v_ff) || cmd.done;
      pend_v_in   = pend_v_ff;
      pend_pos_in = pend_pos_ff;
      pend_tot_in = pend_tot_ff;
      rsp_v_in    = rsp_v_ff && !rsp_ready;
      rsp_pos_in  = rsp_pos_ff;
      rsp_tot_in  = rsp_tot_ff;
      rsp_fin_in  = rsp_fin_ff;
      if (load_rsp) begin
         rsp_v_in   = 1'b1;
         rsp_pos_in = pend_pos_ff;
         rsp_tot_in = pend_tot_ff;
         rsp_fin_in = cmd.done;
      end
      if (cmd.visit) begin
         pend_v_in   = 1'b1;
         pend_pos_in = cur_in;
         pend_tot_in = total_in;
      end else if (cmd.done) begin
         pend_v_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_v_ff   <= 1'b0;
         served_ff <= '0;
         found_ff  <= 1'b0;
         cur_ff    <= '0;
         total_ff  <= '0;
         pend_v_ff <= 1'b0;
         rsp_v_ff  <= 1'b0;
      end else begin
         rd_v_ff   <= cmd.rd_en;
         served_ff <= served_in;
         found_ff  <= found_in;
         cur_ff    <= cur_in;
         total_ff  <= total_in;
         pend_v_ff <= pend_v_in;
         rsp_v_ff  <= rsp_v_in;
      end
   end

   always_ff @(posedge clock) begin
      best_key_ff <= best_key_in;
      best_val_ff <= best_val_in;
      best_ix_ff  <= best_ix_in;
      pend_pos_ff <= pend_pos_in;
      pend_tot_ff <= pend_tot_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_fin_ff  <= rsp_fin_in;
   end

   assign sts.found   = found_ff;
   assign sts.slot_ok = !pend_v_ff || rsp_free;
   assign sts.done_ok = rsp_free;

   assign out_ext        = {{CYL_W{1'b0}}, rsp_pos_ff};
   assign rsp_valid      = rsp_v_ff;
   assign rsp_position   = out_ext[CYL_W-1:0];
   assign rsp_seek_total = rsp_tot_ff;
   assign rsp_final_item = rsp_fin_ff;

endmodule
`default_nettype wire

[design/dss_controller.sv]
// Controller: load, per-pass scan sequencing and policy phase changes.
// Depends on dss_pkg.
`timescale 1ns / 1ps
`default_nettype none
module dss_controller import dss_pkg::*; #(
   parameter int MAX_REQUESTS = 32,
   localparam int IDX_W       = $clog2(MAX_REQUESTS),
   localparam int CNT_W       = $clog2(MAX_REQUESTS + 1)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_is_last,
   output logic                   req_ready,
   input  wire logic [MODE_W-1:0] sched_mode,
   output cmd_type                cmd,
   input  wire sts_type           sts,
   output logic [IDX_W-1:0]       wr_ix,
   output logic [IDX_W-1:0]       rd_ix
);

   typedef enum logic [7:0] {
      S_LOAD  = 8'b0000_0001,
      S_START = 8'b0000_0010,
      S_SCAN  = 8'b0000_0100,
      S_TAIL  = 8'b0000_1000,
      S_PICK  = 8'b0001_0000,
      S_LAST  = 8'b0010_0000,
      S_ZERO  = 8'b0100_0000,
      S_FIN   = 8'b1000_0000
   } state_type;

   state_type       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] ix_ff, ix_in;
   phase_type       phase_ff, phase_in;

   assign wr_ix     = count_ff[IDX_W-1:0];
   assign rd_ix     = ix_ff[IDX_W-1:0];
   assign req_ready = (state_ff == S_LOAD);

   always_comb begin
      state_in       = state_ff;
      count_in       = count_ff;
      ix_in          = ix_ff;
      phase_in       = phase_ff;
      cmd            = '0;
      cmd.phase      = phase_ff;
      cmd.vsel       = VS_BEST;
      case (state_ff)
         S_LOAD: begin
            if (req_valid) begin
               if (count_ff < CNT_W'(MAX_REQUESTS)) begin
                  cmd.store_wr = 1'b1;
                  count_in     = count_ff + CNT_W'(1);
               end
               if (req_is_last) begin
                  state_in = S_START;
               end
            end
         end
         S_START: begin
            if (sts.slot_ok) begin
               cmd.served_clr = 1'b1;
               cmd.scan_clr   = 1'b1;
               cmd.visit      = 1'b1;
               cmd.vsel       = VS_START;
               ix_in          = '0;
               phase_in       = (sched_mode == MODE_LOOK || sched_mode == MODE_CSCAN)
                                ? PH_HIGH : PH_NEAR;
               state_in       = S_SCAN;
            end
         end
         S_SCAN: begin
            if (ix_ff < count_ff) begin
               cmd.rd_en = 1'b1;
               ix_in     = ix_ff + CNT_W'(1);
            end else begin
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            state_in = S_PICK;
         end
         S_PICK: begin
            if (sts.found) begin
               if (sts.slot_ok) begin
                  cmd.visit    = 1'b1;
                  cmd.scan_clr = 1'b1;
                  ix_in        = '0;
                  state_in     = S_SCAN;
               end
            end else if (phase_ff == PH_HIGH && sched_mode == MODE_CSCAN) begin
               state_in = S_LAST;
            end else if (phase_ff == PH_HIGH) begin
               phase_in     = PH_DOWN;
               cmd.scan_clr = 1'b1;
               ix_in        = '0;
               state_in     = S_SCAN;
            end else begin
               state_in = S_FIN;
            end
         end
         S_LAST: begin
            if (sts.slot_ok) begin
               cmd.visit = 1'b1;
               cmd.vsel  = VS_LAST;
               state_in  = S_ZERO;
            end
         end
         S_ZERO: begin
            if (sts.slot_ok) begin
               cmd.visit    = 1'b1;
               cmd.vsel     = VS_ZERO;
               cmd.scan_clr = 1'b1;
               phase_in     = PH_UPLOW;
               ix_in        = '0;
               state_in     = S_SCAN;
            end
         end
         S_FIN: begin
            if (sts.done_ok) begin
               cmd.done = 1'b1;
               count_in = '0;
               state_in = S_LOAD;
            end
         end
         default: begin
            state_in = S_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_LOAD;
         count_ff <= '0;
         ix_ff    <= '0;
         phase_ff <= PH_NEAR;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         ix_ff    <= ix_in;
         phase_ff <= phase_in;
      end
   end

endmodule
`default_nettype wire

[design/disk_seek_scheduler.sv]
// Top level of the disk seek scheduler: register block, controller and datapath.
// Depends on dss_pkg, dss_controller, dss_datapath.
`timescale 1ns / 1ps
`default_nettype none
// Requests are loaded one per cycle on the req_ channel; a request beyond
// MAX_REQUESTS is dropped. The transfer with req_is_last set starts the
// scheduling pass, during which req_ready is low. The first result is the
// start cylinder with a total of 0, then one result per visited cylinder,
// final_item marking the last. Policy (sched_mode): 0 nearest first (tie to
// the earliest loaded), 1 look, 2 circular scan (also visits the last
// cylinder and 0); 3 acts as 0. Each visited request costs one scan of the
// request memory, one read per cycle. Registers at byte addresses 0 (mode),
// 4 (start cylinder), 8 (cylinder count, reset 5000); write them only while
// idle.
module disk_seek_scheduler import dss_pkg::*; #(
   parameter int MAX_REQUESTS = 32,
   parameter int CYL_BITS     = 16
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [CYL_W-1:0]   req_cylinder,
   input  wire logic               req_is_last,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [CYL_W-1:0]        rsp_position,
   output logic [TOTAL_W-1:0]      rsp_seek_total,
   output logic                    rsp_final_item,
   input  wire logic               psel,
   input  wire logic               penable,
   input  wire logic               pwrite,
   input  wire logic [ADDR_W-1:0]  paddr,
   input  wire logic [DATA_W-1:0]  pwdata,
   output logic [DATA_W-1:0]       prdata,
   output logic                    pready
);

   localparam int IDX_W = $clog2(MAX_REQUESTS);

   logic [MODE_W-1:0] mode_ff, mode_in;
   logic [CYL_W-1:0]  start_ff, start_in;
   logic [DISK_W-1:0] disk_ff, disk_in;
   logic              wr_en;

   cmd_type          cmd;
   sts_type          sts;
   logic [IDX_W-1:0] wr_ix, rd_ix;

   // register block: written on the access phase of a write transfer
   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      disk_in  = disk_ff;
      if (wr_en) begin
         case (paddr)
            ADDR_MODE:  mode_in  = pwdata[MODE_W-1:0];
            ADDR_START: start_in = pwdata[CYL_W-1:0];
            ADDR_DISK:  disk_in  = pwdata[DISK_W-1:0];
            default:    ;
         endcase
      end
      case (paddr)
         ADDR_MODE:  prdata = DATA_W'(mode_ff);
         ADDR_START: prdata = DATA_W'(start_ff);
         ADDR_DISK:  prdata = DATA_W'(disk_ff);
         default:    prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SSTF;
         start_ff <= '0;
         disk_ff  <= DISK_RESET;
      end else begin
         mode_ff  <= mode_in;
         start_ff <= start_in;
         disk_ff  <= disk_in;
      end
   end

   dss_controller #(
      .MAX_REQUESTS (MAX_REQUESTS)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_ready   (req_ready),
      .sched_mode  (mode_ff),
      .cmd         (cmd),
      .sts         (sts),
      .wr_ix       (wr_ix),
      .rd_ix       (rd_ix)
   );

   dss_datapath #(
      .MAX_REQUESTS (MAX_REQUESTS),
      .CYL_BITS     (CYL_BITS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .wr_ix          (wr_ix),
      .rd_ix          (rd_ix),
      .req_cylinder   (req_cylinder),
      .start_cylinder (start_ff),
      .disk_cylinders (disk_ff),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_position   (rsp_position),
      .rsp_seek_total (rsp_seek_total),
      .rsp_final_item (rsp_final_item)
   );

endmodule
`default_nettype wire

[design/dss_checker.sv]
// Port-level checks on the disk seek scheduler, bound to the top level.
// Depends on dss_pkg and disk_seek_scheduler.
`timescale 1ns / 1ps
`default_nettype none
module dss_checker import dss_pkg::*; (
   input wire logic               clock,
   input wire logic               reset,
   input wire logic               req_valid,
   input wire logic               req_ready,
   input wire logic               req_is_last,
   input wire logic               rsp_valid,
   input wire logic               rsp_ready,
   input wire logic [CYL_W-1:0]   rsp_position,
   input wire logic [TOTAL_W-1:0] rsp_seek_total,
   input wire logic               rsp_final_item
);

   // a held result keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_position)
                                 && $stable(rsp_seek_total) && $stable(rsp_final_item))
      else $error("result changed while stalled");

   // no loading while a batch is still being emitted
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_item |-> !req_ready)
      else $error("input ready during scheduling");

   a_last_stops: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_is_last |=> !req_ready)
      else $error("input ready after last request");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind disk_seek_scheduler dss_checker u_chk (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .req_is_last    (req_is_last),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_position   (rsp_position),
   .rsp_seek_total (rsp_seek_total),
   .rsp_final_item (rsp_final_item)
);
`default_nettype wire
